/* rtl/pcs_pkg.sv */
// Shared types and constants for the PID correction step block.
package pcs_pkg;

  localparam int ERR_W   = 16;
  localparam int DT_W    = 16;
  localparam int GAIN_W  = 16;
  localparam int CORR_W  = 32;
  localparam int INTEG_W = 48;
  localparam int SERR_W  = 24;   // scaled error
  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 64;
  localparam int DIV_W   = 24;   // magnitude of the scaled error change
  localparam int CNT_W   = 5;
  localparam int HALF_W  = INTEG_W / 2;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_GAIN_P      = 2'd0;
  localparam logic [1:0] REG_GAIN_I      = 2'd1;
  localparam logic [1:0] REG_GAIN_D      = 2'd2;
  localparam logic [1:0] REG_ERROR_SCALE = 2'd3;

  localparam logic [GAIN_W-1:0] GAIN_P_RST      = 16'd256;
  localparam logic [GAIN_W-1:0] GAIN_I_RST      = 16'd0;
  localparam logic [GAIN_W-1:0] GAIN_D_RST      = 16'd0;
  localparam logic [GAIN_W-1:0] ERROR_SCALE_RST = 16'd256;

  typedef enum logic [2:0] {
    MUL_SCALE,
    MUL_DT,
    MUL_GP,
    MUL_GI_LO,
    MUL_GI_HI,
    MUL_GD
  } mul_sel_t;

  typedef struct packed {
    logic     ld_in;
    mul_sel_t mul_sel;
    logic     ld_err;
    logic     div_start;
    logic     ld_integ;
    logic     acc_clr;
    logic     acc_add;
    logic     acc_hi;
    logic     ld_out;
  } pcs_cmd_t;

  typedef struct packed {
    logic div_done;
  } pcs_stat_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic signed [GAIN_W-1:0] error_scale;
  } pcs_cfg_t;

endpackage

/* rtl/pcs_dp.sv */
// Datapath: shared multiplier, divider, integral, accumulator and output register.
module pcs_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  pcs_pkg::pcs_cmd_t                     cmd,
  input  pcs_pkg::pcs_cfg_t                     cfg,
  input  logic signed [pcs_pkg::ERR_W-1:0]      in_error,
  input  logic        [pcs_pkg::DT_W-1:0]       in_elapsed,
  output pcs_pkg::pcs_stat_t                    stat,
  output logic signed [pcs_pkg::CORR_W-1:0]     corr,
  output logic                                  sat
);
  import pcs_pkg::*;

  logic signed [ERR_W-1:0]   e_r;
  logic        [DT_W-1:0]    dt_r;
  logic signed [SERR_W-1:0]  err_r;
  logic signed [SERR_W-1:0]  prev_r;
  logic signed [INTEG_W-1:0] integ_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic                      sat_r;
  logic        [DIV_W-1:0]   quo_r;
  logic        [DT_W-1:0]    rem_r;
  logic        [CNT_W-1:0]   cnt_r;
  logic                      neg_r;
  logic signed [CORR_W-1:0]  corr_r;
  logic                      sat_out_r;

  logic signed [MUL_A_W-1:0]   mul_a;
  logic signed [MUL_B_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]    prod_nxt;
  logic signed [SERR_W:0]      diff;
  logic        [SERR_W:0]      diff_mag;
  logic        [DT_W:0]        trial;
  logic                        trial_ge;
  logic signed [MUL_A_W-1:0]   deriv;
  logic signed [INTEG_W:0]     isum;
  logic signed [INTEG_W-1:0]   integ_nxt;
  logic                        integ_clip;
  logic signed [ACC_W-1:0]     addend;
  logic signed [ACC_W-9:0]     scaled;
  logic signed [CORR_W-1:0]    corr_nxt;
  logic                        corr_clip;

  assign deriv = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = MUL_A_W'(e_r);
    mul_b = MUL_B_W'(cfg.error_scale);
    unique case (cmd.mul_sel)
      MUL_SCALE: begin
        mul_a = MUL_A_W'(e_r);
        mul_b = MUL_B_W'(cfg.error_scale);
      end
      MUL_DT: begin
        mul_a = MUL_A_W'(err_r);
        mul_b = $signed({2'b00, dt_r});
      end
      MUL_GP: begin
        mul_a = MUL_A_W'(err_r);
        mul_b = MUL_B_W'(cfg.gain_p);
      end
      MUL_GI_LO: begin
        mul_a = $signed({1'b0, integ_r[HALF_W-1:0]});
        mul_b = MUL_B_W'(cfg.gain_i);
      end
      MUL_GI_HI: begin
        mul_a = MUL_A_W'($signed(integ_r[INTEG_W-1:HALF_W]));
        mul_b = MUL_B_W'(cfg.gain_i);
      end
      MUL_GD: begin
        mul_a = deriv;
        mul_b = MUL_B_W'(cfg.gain_d);
      end
      default: begin
        mul_a = MUL_A_W'(e_r);
        mul_b = MUL_B_W'(cfg.error_scale);
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  assign diff     = (SERR_W+1)'(err_r) - (SERR_W+1)'(prev_r);
  assign diff_mag = diff[SERR_W] ? (SERR_W+1)'(-diff) : diff;

  // One restoring step per cycle
  assign trial    = {rem_r, quo_r[DIV_W-1]};
  assign trial_ge = trial >= {1'b0, dt_r};

  // Saturating integral update
  assign isum       = (INTEG_W+1)'(integ_r) + (INTEG_W+1)'(prod_r);
  assign integ_clip = isum[INTEG_W] != isum[INTEG_W-1];
  always_comb begin
    if (integ_clip) begin
      integ_nxt = isum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      integ_nxt = isum[INTEG_W-1:0];
    end
  end

  assign addend = cmd.acc_hi ? (ACC_W'(prod_r) <<< HALF_W) : ACC_W'(prod_r);

  // Floor by 256, then clamp to the output range
  assign scaled    = acc_r[ACC_W-1:8];
  assign corr_clip = !((&scaled[ACC_W-9:CORR_W-1]) || !(|scaled[ACC_W-9:CORR_W-1]));
  always_comb begin
    if (corr_clip) begin
      corr_nxt = scaled[ACC_W-9] ? {1'b1, {(CORR_W-1){1'b0}}} : {1'b0, {(CORR_W-1){1'b1}}};
    end else begin
      corr_nxt = scaled[CORR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      integ_r <= '0;
      cnt_r   <= '0;
    end else begin
      if (cmd.div_start) begin
        prev_r <= err_r;
        cnt_r  <= CNT_W'(DIV_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end
      if (cmd.ld_integ) begin
        integ_r <= integ_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (cmd.ld_in) begin
      e_r  <= in_error;
      dt_r <= (in_elapsed == '0) ? DT_W'(1) : in_elapsed;
    end
    if (cmd.ld_err) begin
      err_r <= prod_r[SERR_W+7:8];
    end
    if (cmd.div_start) begin
      quo_r <= diff_mag[DIV_W-1:0];
      rem_r <= '0;
      neg_r <= diff[SERR_W];
    end else if (cnt_r != '0) begin
      rem_r <= trial_ge ? DT_W'(trial - {1'b0, dt_r}) : trial[DT_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], trial_ge};
    end
    if (cmd.acc_clr) begin
      acc_r <= '0;
      sat_r <= 1'b0;
    end else begin
      if (cmd.acc_add) begin
        acc_r <= acc_r + addend;
      end
      if (cmd.ld_integ && integ_clip) begin
        sat_r <= 1'b1;
      end
    end
    if (cmd.ld_out) begin
      corr_r    <= corr_nxt;
      sat_out_r <= sat_r | corr_clip;
    end
  end

  assign stat.div_done = (cnt_r == '0);
  assign corr          = corr_r;
  assign sat           = sat_out_r;

endmodule

/* rtl/pcs_ctrl.sv */
// Controller: sequences one sample through the datapath and owns the output handshake.
module pcs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  pcs_pkg::pcs_stat_t  stat,
  output pcs_pkg::pcs_cmd_t   cmd
);
  import pcs_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MSC  = 4'd1;
  localparam logic [3:0] S_ERR  = 4'd2;
  localparam logic [3:0] S_MDT  = 4'd3;
  localparam logic [3:0] S_INT  = 4'd4;
  localparam logic [3:0] S_AGP  = 4'd5;
  localparam logic [3:0] S_AGL  = 4'd6;
  localparam logic [3:0] S_AGH  = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_MGD  = 4'd9;
  localparam logic [3:0] S_AGD  = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    cmd.mul_sel   = MUL_SCALE;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.ld_in   = 1'b1;
          cmd.acc_clr = 1'b1;
          state_nxt   = S_MSC;
        end
      end
      S_MSC: begin
        cmd.mul_sel = MUL_SCALE;
        state_nxt   = S_ERR;
      end
      S_ERR: begin
        cmd.ld_err = 1'b1;
        state_nxt  = S_MDT;
      end
      S_MDT: begin
        cmd.mul_sel   = MUL_DT;
        cmd.div_start = 1'b1;
        state_nxt     = S_INT;
      end
      S_INT: begin
        cmd.ld_integ = 1'b1;
        cmd.mul_sel  = MUL_GP;
        state_nxt    = S_AGP;
      end
      S_AGP: begin
        cmd.acc_add = 1'b1;
        cmd.mul_sel = MUL_GI_LO;
        state_nxt   = S_AGL;
      end
      S_AGL: begin
        cmd.acc_add = 1'b1;
        cmd.mul_sel = MUL_GI_HI;
        state_nxt   = S_AGH;
      end
      S_AGH: begin
        cmd.acc_add = 1'b1;
        cmd.acc_hi  = 1'b1;
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_nxt = S_MGD;
        end
      end
      S_MGD: begin
        cmd.mul_sel = MUL_GD;
        state_nxt   = S_AGD;
      end
      S_AGD: begin
        cmd.acc_add = 1'b1;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.ld_out    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

/* rtl/pid_correction_step.sv */
// Top level of the PID correction step: register file, controller and datapath.
//
//   channel   direction  payload
//   in_*      in         tdata = {elapsed_ms[31:16], error_sample[15:0]}
//   out_*     out        tdata = correction[31:0], tuser = saturated
//   cfg_*     in         APB: gain_p 0x0, gain_i 0x4, gain_d 0x8, error_scale 0xC
//
// A sample runs through the controller states from acceptance to a loaded result;
// the 24-step restoring divider for the derivative runs alongside the gain terms and
// is waited on in S_DIV. No new sample is taken until the last result is loaded.
// A new sample is accepted once the controller is idle, even while the previous
// result still waits in the output register; a stalled output holds the last step.
// Reset (rst_n low, synchronous) restores the gains and clears the integral
// and the previous error.
module pid_correction_step (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [15:0] error_sample, [31:16] elapsed_ms
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [31:0] correction
  output logic [0:0]  out_tuser,   // [0] saturated
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import pcs_pkg::*;

  logic [GAIN_W-1:0] gain_p_r, gain_i_r, gain_d_r, error_scale_r;
  logic [1:0]        reg_idx;
  logic              cfg_wr;
  pcs_cfg_t          cfg;
  pcs_cmd_t          cmd;
  pcs_stat_t         stat;
  logic signed [CORR_W-1:0] corr;
  logic              sat;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r      <= GAIN_P_RST;
      gain_i_r      <= GAIN_I_RST;
      gain_d_r      <= GAIN_D_RST;
      error_scale_r <= ERROR_SCALE_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_GAIN_P:      gain_p_r      <= cfg_pwdata[GAIN_W-1:0];
        REG_GAIN_I:      gain_i_r      <= cfg_pwdata[GAIN_W-1:0];
        REG_GAIN_D:      gain_d_r      <= cfg_pwdata[GAIN_W-1:0];
        REG_ERROR_SCALE: error_scale_r <= cfg_pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GAIN_P:      cfg_prdata = {16'd0, gain_p_r};
      REG_GAIN_I:      cfg_prdata = {16'd0, gain_i_r};
      REG_GAIN_D:      cfg_prdata = {16'd0, gain_d_r};
      REG_ERROR_SCALE: cfg_prdata = {16'd0, error_scale_r};
      default:         cfg_prdata = '0;
    endcase
  end

  assign cfg.gain_p      = gain_p_r;
  assign cfg.gain_i      = gain_i_r;
  assign cfg.gain_d      = gain_d_r;
  assign cfg.error_scale = error_scale_r;

  pcs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  pcs_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cfg        (cfg),
    .in_error   (in_tdata[15:0]),
    .in_elapsed (in_tdata[31:16]),
    .stat       (stat),
    .corr       (corr),
    .sat        (sat)
  );

  assign out_tdata = corr;
  assign out_tuser = sat;

endmodule

/* rtl/pcs_chk.sv */
// Port-level checker for the PID correction step, bound to the top level.
module pcs_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [0:0]  out_tuser,
  input logic        cfg_pready
);

  // stalled result holds its transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output transaction changed");

  // one sample at a time: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a sample is in flight");

  // no result can appear in the cycle after acceptance
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result appeared too early");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("configuration port not ready");

endmodule

bind pid_correction_step pcs_chk u_pcs_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_pready (cfg_pready)
);
